>>> hdl/gyro_frame_parser_core_assert.svh
// ----------------------------------------------------------------------------
// gyro_frame_parser_core_assert.svh
// Assertion macros for the gyro frame parser, compiled out under SYNTH.
// ----------------------------------------------------------------------------
`ifndef GYRO_FRAME_PARSER_CORE_ASSERT_SVH
`define GYRO_FRAME_PARSER_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define GFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gyro frame parser: same-cycle check failed");
// next-cycle implication
`define GFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gyro frame parser: next-cycle check failed");
`else
`define GFP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define GFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/gfp_pkg.sv
// ----------------------------------------------------------------------------
// gfp_pkg
// Shared constants, register indexes and status codes of the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package gfp_pkg;

    // frame layout
    localparam int PACKET_BYTES = 11;
    localparam int FRAME_BYTES  = 2 * PACKET_BYTES;
    localparam int COUNT_MAX    = FRAME_BYTES + 1;

    localparam int COUNT_W = 5;

    localparam logic [COUNT_W-1:0] POS_HDR_A    = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] POS_HDR_B    = COUNT_W'(PACKET_BYTES);
    localparam logic [COUNT_W-1:0] POS_SUM_A    = COUNT_W'(PACKET_BYTES - 1);
    localparam logic [COUNT_W-1:0] POS_SUM_B    = COUNT_W'(FRAME_BYTES - 1);
    localparam logic [COUNT_W-1:0] POS_RATE_LO  = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] POS_RATE_HI  = COUNT_W'(7);
    localparam logic [COUNT_W-1:0] POS_ANGLE_LO = COUNT_W'(PACKET_BYTES + 6);
    localparam logic [COUNT_W-1:0] POS_ANGLE_HI = COUNT_W'(PACKET_BYTES + 7);
    localparam logic [COUNT_W-1:0] POS_FRAME    = COUNT_W'(FRAME_BYTES);
    localparam logic [COUNT_W-1:0] POS_MAX      = COUNT_W'(COUNT_MAX);

    // field widths
    localparam int BYTE_W  = 8;
    localparam int RAW_W   = 16;
    localparam int RATE_W  = 23;
    localparam int ANGLE_W = 22;
    localparam int CFG_W   = 16;
    localparam int ACC_W   = 25;

    // fixed-point scaling: 2000/32768 deg/s in 1/2048 units, 180/32768 deg in 1/8192
    localparam logic signed [RATE_W-1:0] RATE_SCALE  = 23'sd125;
    localparam logic signed [ACC_W-1:0]  ANGLE_SCALE = 25'sd45;
    localparam logic signed [ACC_W-1:0]  FULL_TURN   = 25'sd2949120;
    localparam logic signed [ACC_W-1:0]  ANGLE_MIN   = -25'sd2097152;

    // configuration register indexes
    localparam logic REG_HEADER_BYTE = 1'b0;
    localparam logic REG_WRAP_LIMIT  = 1'b1;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd85;
    localparam logic [CFG_W-1:0]  WRAP_RESET   = 16'd8192;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_WRONG_LEN = 2'd1;
    localparam t_status ST_BAD_HDR   = 2'd2;
    localparam t_status ST_BAD_SUM   = 2'd3;

endpackage

`default_nettype wire

>>> hdl/gfp_in_if.sv
// ----------------------------------------------------------------------------
// gfp_in_if
// Byte channel into the parser: one received byte and its end-of-burst mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfp_in_if
    import gfp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_burst;

    modport source (output valid, output data_byte, output end_of_burst, input ready);
    modport sink   (input valid, input data_byte, input end_of_burst, output ready);
endinterface

`default_nettype wire

>>> hdl/gfp_out_if.sv
// ----------------------------------------------------------------------------
// gfp_out_if
// Result channel out of the parser: burst status and the held values.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfp_out_if
    import gfp_pkg::*;
();
    logic                      valid;
    logic                      ready;
    t_status                   status;
    logic signed [RATE_W-1:0]  angular_rate;
    logic signed [ANGLE_W-1:0] angle;

    modport source (output valid, output status, output angular_rate, output angle,
                    input ready);
    modport sink   (input valid, input status, input angular_rate, input angle,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/gyro_frame_parser_core.sv
// ----------------------------------------------------------------------------
// gyro_frame_parser_core
// Checks two-packet sensor frames byte by byte and reports one result per burst.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte carries one received byte a beat, with end_of_burst set on the
//   last byte before the idle line. o_result gives one beat per burst end:
//   status (ok, wrong length, bad header, bad checksum) and the held rate and
//   angle, updated only by good frames.
//   Registers: index 0 header byte, index 1 wrap limit (signed), written
//   through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Timing:
//   One byte is accepted every cycle while no final byte is held back. A byte
//   goes into the input register, then the frame state and the result
//   register are updated in one pass from it. The scaling products are
//   constant multiplies on the raw words as updated by the current byte.
// Reset:
//   Synchronous, active low: empties both registers, restores the register
//   reset values and clears the frame state and held values.
// Stall:
//   While a result waits unaccepted, non-final bytes still flow through; a
//   final byte waits in the input register and i_byte.ready falls with it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gyro_frame_parser_core_assert.svh"

module gyro_frame_parser_core
    import gfp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    gfp_in_if.sink                i_byte,
    gfp_out_if.source             o_result,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    // configuration registers
    logic [BYTE_W-1:0] r_header_byte;
    logic [CFG_W-1:0]  r_wrap_limit;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // frame state
    logic [COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [BYTE_W-1:0]  r_first_sum, n_first_sum;
    logic [BYTE_W-1:0]  r_second_sum, n_second_sum;
    logic               r_headers_good, n_headers_good;
    logic               r_sums_good, n_sums_good;
    logic [RAW_W-1:0]   r_rate_raw, n_rate_raw;
    logic [RAW_W-1:0]   r_angle_raw, n_angle_raw;
    logic [RATE_W-1:0]  r_rate_held, n_rate_held;
    logic [ANGLE_W-1:0] r_angle_held, n_angle_held;

    // result register
    logic               r_out_valid;
    t_status            r_status, n_status;

    logic               w_fire;
    logic               w_in_take;
    logic signed [RATE_W-1:0] w_rate_scaled;
    logic signed [ACC_W-1:0]  w_angle_scaled;
    logic signed [ACC_W-1:0]  w_angle_wrapped;

    // handshakes: a final byte moves on only when the result register frees up
    assign w_fire    = r_in_valid && (!r_in_last || !r_out_valid || o_result.ready);
    assign w_in_take = i_byte.valid && i_byte.ready;
    assign i_byte.ready = !r_in_valid || w_fire;

    // configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte <= HEADER_RESET;
            r_wrap_limit  <= WRAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HEADER_BYTE: r_header_byte <= i_cfg_data[BYTE_W-1:0];
                REG_WRAP_LIMIT:  r_wrap_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.end_of_burst;
        end
    end

    // frame checks and field capture for the byte in the input register
    always_comb begin
        n_headers_good = r_headers_good;
        n_sums_good    = r_sums_good;
        n_first_sum    = r_first_sum;
        n_second_sum   = r_second_sum;
        n_rate_raw     = r_rate_raw;
        n_angle_raw    = r_angle_raw;
        n_byte_count   = r_byte_count;

        if (r_byte_count < POS_FRAME) begin
            if ((r_byte_count == POS_HDR_A || r_byte_count == POS_HDR_B)
                    && r_in_byte != r_header_byte) begin
                n_headers_good = 1'b0;
            end
            if (r_byte_count < POS_SUM_A) begin
                n_first_sum = r_first_sum + r_in_byte;
            end else if (r_byte_count == POS_SUM_A) begin
                if (r_in_byte != r_first_sum) n_sums_good = 1'b0;
            end else if (r_byte_count < POS_SUM_B) begin
                n_second_sum = r_second_sum + r_in_byte;
            end else if (r_in_byte != r_second_sum) begin
                n_sums_good = 1'b0;
            end

            if (r_byte_count == POS_RATE_LO) begin
                n_rate_raw[7:0] = r_in_byte;
            end else if (r_byte_count == POS_RATE_HI) begin
                n_rate_raw[15:8] = r_in_byte;
            end else if (r_byte_count == POS_ANGLE_LO) begin
                n_angle_raw[7:0] = r_in_byte;
            end else if (r_byte_count == POS_ANGLE_HI) begin
                n_angle_raw[15:8] = r_in_byte;
            end
        end
        // saturating byte counter
        if (r_byte_count < POS_MAX) n_byte_count = r_byte_count + 1'b1;
    end

    // fixed-point scaling and angle wrap
    assign w_rate_scaled  = $signed({{(RATE_W-RAW_W){n_rate_raw[RAW_W-1]}}, n_rate_raw})
                            * RATE_SCALE;
    assign w_angle_scaled = $signed({{(ACC_W-RAW_W){n_angle_raw[RAW_W-1]}}, n_angle_raw})
                            * ANGLE_SCALE;

    always_comb begin
        w_angle_wrapped = w_angle_scaled;
        if ($signed(n_angle_raw) > $signed(r_wrap_limit)) begin
            w_angle_wrapped = w_angle_scaled - FULL_TURN;
        end
        // only the low side can leave the 22-bit range
        if (w_angle_wrapped < ANGLE_MIN) w_angle_wrapped = ANGLE_MIN;
    end

    // burst status, in priority order: length, headers, checksums
    always_comb begin
        n_rate_held  = r_rate_held;
        n_angle_held = r_angle_held;
        if (n_byte_count != POS_FRAME) begin
            n_status = ST_WRONG_LEN;
        end else if (!n_headers_good) begin
            n_status = ST_BAD_HDR;
        end else if (!n_sums_good) begin
            n_status = ST_BAD_SUM;
        end else begin
            n_status     = ST_OK;
            n_rate_held  = w_rate_scaled;
            n_angle_held = w_angle_wrapped[ANGLE_W-1:0];
        end
    end

    // frame state update; burst end starts a fresh burst
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_first_sum    <= '0;
            r_second_sum   <= '0;
            r_headers_good <= 1'b1;
            r_sums_good    <= 1'b1;
            r_rate_raw     <= '0;
            r_angle_raw    <= '0;
            r_rate_held    <= '0;
            r_angle_held   <= '0;
        end else if (w_fire) begin
            r_rate_raw  <= n_rate_raw;
            r_angle_raw <= n_angle_raw;
            if (r_in_last) begin
                r_byte_count   <= '0;
                r_first_sum    <= '0;
                r_second_sum   <= '0;
                r_headers_good <= 1'b1;
                r_sums_good    <= 1'b1;
                r_rate_held    <= n_rate_held;
                r_angle_held   <= n_angle_held;
            end else begin
                r_byte_count   <= n_byte_count;
                r_first_sum    <= n_first_sum;
                r_second_sum   <= n_second_sum;
                r_headers_good <= n_headers_good;
                r_sums_good    <= n_sums_good;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_last) begin
            r_status <= n_status;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_status;
    assign o_result.angular_rate = r_rate_held;
    assign o_result.angle        = r_angle_held;

    // checks
    `GFP_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, w_fire && r_in_last, r_out_valid)
    `GFP_ASSERT_NEXT(a_burst_end_clears, i_clk, i_rst_n, w_fire && r_in_last,
                     r_byte_count == '0 && r_headers_good && r_sums_good)
    `GFP_ASSERT_NEXT(a_count_steps, i_clk, i_rst_n,
                     w_fire && !r_in_last && r_byte_count != POS_MAX,
                     r_byte_count == $past(r_byte_count) + 1'b1)
    `GFP_ASSERT_NOW(a_held_result_blocks_last, i_clk, i_rst_n,
                    r_in_valid && r_in_last && r_out_valid && !o_result.ready,
                    !i_byte.ready)

endmodule

`default_nettype wire
